// ===== rtl/core/rfpe_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RF remote pulse encoder: phase codes, register indexes,
// register reset values and the structs shared by the top level and the frame generator.
// No dependencies.
package rfpe_pkg;

    localparam int ID_BITS_DEF  = 16;
    localparam int KEY_BITS_DEF = 7;

    localparam int LEN_W    = 10;
    localparam int REPEAT_W = 8;
    localparam int CFG_IDX_W = 2;

    // request codes carried in req_type
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_REPEATS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LEN       = 2'd3;

    // register reset values
    localparam logic [REPEAT_W-1:0] FRAME_REPEATS_RST = 8'd180;
    localparam logic [LEN_W-1:0]    START_LEN_RST     = 10'd525;
    localparam logic [LEN_W-1:0]    ZERO_LEN_RST      = 10'd110;
    localparam logic [LEN_W-1:0]    ONE_LEN_RST       = 10'd305;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [REPEAT_W-1:0] frame_repeats;
        logic [LEN_W-1:0]    start_len;
        logic [LEN_W-1:0]    zero_len;
        logic [LEN_W-1:0]    one_len;
    } cfg_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic done_res;
    } result_t;

endpackage

// ===== rtl/core/rfpe_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: valid/ready handshake with a start or tick request.
// Width of the ID and key follow the interface parameters.
interface rfpe_req_if #(
    parameter int ID_BITS  = 16,
    parameter int KEY_BITS = 7
);
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [ID_BITS-1:0]  remote_id;
    logic [KEY_BITS-1:0] key_code;

    modport source (output valid, output req_type, output remote_id, output key_code,
                    input ready);
    modport sink   (input valid, input req_type, input remote_id, input key_code,
                    output ready);
endinterface

// ===== rtl/core/rfpe_res_if.sv =====
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the pin level and status flags.
// No dependencies.
interface rfpe_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic done_res;

    modport source (output valid, output pin_level, output busy_res, output done_res,
                    input ready);
    modport sink   (input valid, input pin_level, input busy_res, input done_res,
                     output ready);
endinterface

// ===== rtl/core/rfpe_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// No dependencies.
interface rfpe_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rfpe_frame_gen.sv =====
`timescale 1ns / 1ps
// Frame generator: phase, bit and duration state of the encoder, advanced once per beat.
// Depends on rfpe_pkg.
module rfpe_frame_gen #(
    parameter int ID_BITS  = rfpe_pkg::ID_BITS_DEF,
    parameter int KEY_BITS = rfpe_pkg::KEY_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  req_type,
    input  logic [ID_BITS-1:0]    remote_id,
    input  logic [KEY_BITS-1:0]   key_code,
    input  rfpe_pkg::cfg_t        cfg,
    output rfpe_pkg::result_t     result
);
    import rfpe_pkg::*;

    localparam int TOTAL = ID_BITS + KEY_BITS;
    localparam int IDX_W = $clog2(TOTAL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL - 1);

    logic [TOTAL-1:0]    shift_reg, shift_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                half_reg, half_next;
    logic                level_reg, level_next;
    logic [LEN_W-1:0]    dur_reg, dur_next;
    logic [REPEAT_W-1:0] frame_reg, frame_next;
    phase_t              phase_reg, phase_next;

    logic                cur_bit;
    logic [LEN_W-1:0]    bit_len;
    logic [LEN_W:0]      dur_inc;
    logic                start_done;
    logic                bit_done;

    assign cur_bit    = shift_reg[TOTAL-1];
    assign bit_len    = cur_bit ? cfg.one_len : cfg.zero_len;
    assign dur_inc    = {1'b0, dur_reg} + {{LEN_W{1'b0}}, 1'b1};
    // a length of zero ends after one tick, same as a length of one
    assign start_done = dur_inc >= {1'b0, cfg.start_len};
    assign bit_done   = dur_inc >= {1'b0, bit_len};

    always_comb
    begin
        shift_next = shift_reg;
        idx_next   = idx_reg;
        half_next  = half_reg;
        level_next = level_reg;
        dur_next   = dur_reg;
        frame_next = frame_reg;
        phase_next = phase_reg;
        result     = '0;

        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE) begin
                shift_next = {remote_id, key_code};
                idx_next   = '0;
                half_next  = 1'b0;
                level_next = 1'b1;
                dur_next   = '0;
                frame_next = '0;
                phase_next = PH_START;
            end
            // report the level now current; start while busy is dropped
            result.pin_level = (phase_next == PH_START) ? 1'b1 :
                               (phase_next == PH_DATA)  ? ~level_next : 1'b0;
            result.busy_res  = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_START:
                begin
                    result.pin_level = 1'b1;
                    result.busy_res  = 1'b1;
                    if (start_done) begin
                        dur_next   = '0;
                        idx_next   = '0;
                        half_next  = 1'b0;
                        level_next = 1'b1;
                        phase_next = PH_DATA;
                    end else begin
                        dur_next = dur_inc[LEN_W-1:0];
                    end
                end
                PH_DATA:
                begin
                    result.pin_level = ~level_reg;
                    result.busy_res  = 1'b1;
                    if (bit_done) begin
                        dur_next   = '0;
                        level_next = ~level_reg;
                        if (!cur_bit && !half_reg) begin
                            half_next = 1'b1;
                        end else begin
                            half_next = 1'b0;
                            // rotate so the frame is intact again for the repeat
                            shift_next = {shift_reg[TOTAL-2:0], shift_reg[TOTAL-1]};
                            idx_next   = idx_reg + IDX_W'(1);
                            if (idx_reg == LAST_IDX) begin
                                idx_next   = '0;
                                level_next = 1'b1;
                                if (frame_reg >= cfg.frame_repeats) begin
                                    phase_next      = PH_IDLE;
                                    frame_next      = '0;
                                    result.done_res = 1'b1;
                                end else begin
                                    frame_next = frame_reg + REPEAT_W'(1);
                                    phase_next = PH_START;
                                end
                            end
                        end
                    end else begin
                        dur_next = dur_inc[LEN_W-1:0];
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shift_reg <= '0;
            idx_reg   <= '0;
            half_reg  <= 1'b0;
            level_reg <= 1'b1;
            dur_reg   <= '0;
            frame_reg <= '0;
            phase_reg <= PH_IDLE;
        end else if (step) begin
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
            level_reg <= level_next;
            dur_reg   <= dur_next;
            frame_reg <= frame_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== rtl/core/rf_remote_pulse_encoder.sv =====
`timescale 1ns / 1ps
// Top level of the RF remote pulse encoder: channel registers, configuration registers.
// Depends on rfpe_pkg, rfpe_req_if, rfpe_res_if, rfpe_cfg_if and rfpe_frame_gen.
//
//  Channel | Dir | Handshake   | Beat carries
//  --------+-----+-------------+------------------------------------------
//  req     | in  | valid/ready | req_type, remote_id, key_code
//  res     | out | valid/ready | pin_level, busy_res, done_res
//  cfg     | in  | valid/ready | index, data (always ready)
//
// Every request beat yields exactly one result beat, passing first through the request register
// and then through the result register. A beat can be taken every cycle while res does not
// stall; the request register advances into the frame generator whenever the result register
// is empty or its beat is taken in the same cycle.
// A stall on res holds both registers and drops req.ready once the request register fills.
// rst_n clears the phase to idle and loads the register reset values.
module rf_remote_pulse_encoder #(
    parameter int ID_BITS  = rfpe_pkg::ID_BITS_DEF,
    parameter int KEY_BITS = rfpe_pkg::KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rfpe_req_if.sink   req,
    rfpe_res_if.source res,
    rfpe_cfg_if.sink   cfg
);
    import rfpe_pkg::*;

    // request stage
    logic                in_valid_reg;
    logic                in_type_reg;
    logic [ID_BITS-1:0]  in_id_reg;
    logic [KEY_BITS-1:0] in_key_reg;

    // result stage
    logic                out_valid_reg;
    result_t             out_reg;

    cfg_t                cfg_reg;
    result_t             gen_result;
    logic                advance;

    // move a request beat into the generator when the result stage can take it
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    assign res.valid     = out_valid_reg;
    assign res.pin_level = out_reg.pin_level;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (req.ready) begin
            in_valid_reg <= req.valid;
        end
    end

    // request payload needs no reset; load it on every accepted beat
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            in_type_reg <= req.req_type;
            in_id_reg   <= req.remote_id;
            in_key_reg  <= req.key_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (res.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_reg <= gen_result;
        end
    end

    // configuration registers; writes take effect at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.frame_repeats <= FRAME_REPEATS_RST;
            cfg_reg.start_len     <= START_LEN_RST;
            cfg_reg.zero_len      <= ZERO_LEN_RST;
            cfg_reg.one_len       <= ONE_LEN_RST;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_FRAME_REPEATS: cfg_reg.frame_repeats <= cfg.data[REPEAT_W-1:0];
                CFG_START_LEN:     cfg_reg.start_len     <= cfg.data;
                CFG_ZERO_LEN:      cfg_reg.zero_len      <= cfg.data;
                CFG_ONE_LEN:       cfg_reg.one_len       <= cfg.data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    rfpe_frame_gen #(
        .ID_BITS  (ID_BITS),
        .KEY_BITS (KEY_BITS)
    ) u_frame_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .req_type  (in_type_reg),
        .remote_id (in_id_reg),
        .key_code  (in_key_reg),
        .cfg       (cfg_reg),
        .result    (gen_result)
    );

endmodule
